[design/mlr_pkg.sv]
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and codes for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [2:0] {
    OCT_0 = 3'd0,
    OCT_1 = 3'd1,
    OCT_2 = 3'd2,
    OCT_3 = 3'd3,
    OCT_4 = 3'd4,
    OCT_5 = 3'd5,
    OCT_6 = 3'd6,
    OCT_7 = 3'd7
  } octant_e;

endpackage

[design/mlr_req_if.sv]
// ----------------------------------------------------------------------------
// mlr_req_if
// Request channel: start/step command and line endpoints.
// ----------------------------------------------------------------------------
interface mlr_req_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

[design/mlr_pix_if.sv]
// ----------------------------------------------------------------------------
// mlr_pix_if
// Result channel: one pixel (or an idle marker) per request.
// ----------------------------------------------------------------------------
interface mlr_pix_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         pixel_valid;
  logic                         pixel_last;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, pixel_last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, pixel_last, output ready);
endinterface

[design/midpoint_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Eight-zone midpoint line walker: start loads a line and emits its first pixel,
// each step emits the next pixel, or an idle marker when no line is active.
// The result of an accepted request is registered in the output register.
// Throughput: 1 request per cycle; a new request is taken while the result
// register is empty or being drained. The clock period is set by the start
// setup: endpoint difference, zone compare and remap in front of the result register.
// Reset: no line active, result register empty.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
  import mlr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mlr_req_if.sink  req_i,
  mlr_pix_if.source pix_o
);

  localparam int WB = COORD_BITS + 1;
  localparam int IB = COORD_BITS + 3;
  localparam int DB = COORD_BITS + 4;

  typedef logic signed [WB-1:0] wide_t;
  typedef logic signed [IB-1:0] inc_t;
  typedef logic signed [DB-1:0] dec_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
  } point_t;

  function automatic point_t to_zero(octant_e z, point_t p);
    point_t r;
    unique case (z)
      OCT_0: begin r.x = p.x;  r.y = p.y;  end
      OCT_1: begin r.x = p.y;  r.y = p.x;  end
      OCT_2: begin r.x = p.y;  r.y = -p.x; end
      OCT_3: begin r.x = -p.x; r.y = p.y;  end
      OCT_4: begin r.x = -p.x; r.y = -p.y; end
      OCT_5: begin r.x = -p.y; r.y = -p.x; end
      OCT_6: begin r.x = -p.y; r.y = p.x;  end
      OCT_7: begin r.x = p.x;  r.y = -p.y; end
    endcase
    return r;
  endfunction

  function automatic point_t from_zero(octant_e z, point_t p);
    point_t r;
    unique case (z)
      OCT_0: begin r.x = p.x;  r.y = p.y;  end
      OCT_1: begin r.x = p.y;  r.y = p.x;  end
      OCT_2: begin r.x = -p.y; r.y = p.x;  end
      OCT_3: begin r.x = -p.x; r.y = p.y;  end
      OCT_4: begin r.x = -p.x; r.y = -p.y; end
      OCT_5: begin r.x = -p.y; r.y = -p.x; end
      OCT_6: begin r.x = p.y;  r.y = -p.x; end
      OCT_7: begin r.x = p.x;  r.y = -p.y; end
    endcase
    return r;
  endfunction

  // line state
  octant_e octant_q, octant_d;
  wide_t   walk_x_q, walk_x_d;
  wide_t   walk_y_q, walk_y_d;
  wide_t   stop_x_q, stop_x_d;
  dec_t    decision_q, decision_d;
  inc_t    inc_straight_q, inc_straight_d;
  inc_t    inc_diagonal_q, inc_diagonal_d;
  logic    active_q, active_d;

  // result register
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] pixel_x_q, pixel_x_d;
  logic signed [COORD_BITS-1:0] pixel_y_q, pixel_y_d;
  logic                         pixel_valid_q, pixel_valid_d;
  logic                         pixel_last_q, pixel_last_d;

  logic    req_fire;
  logic    is_start;
  wide_t   sx, sy, ex, ey;
  wide_t   dxs, dys, adx, ady;
  wide_t   dx0, dy0;
  octant_e oct_new;
  point_t  ws, we;
  wide_t   nwx, nwy;
  logic    go_diag;
  logic    step_last;
  point_t  emit_pt;
  octant_e emit_oct;
  point_t  map_pt;

  assign req_i.ready = !out_valid_q || pix_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_start    = (req_i.cmd == CMD_START);

  // start setup
  always_comb begin
    sx  = WB'(req_i.start_x);
    sy  = WB'(req_i.start_y);
    ex  = WB'(req_i.end_x);
    ey  = WB'(req_i.end_y);
    dxs = ex - sx;
    dys = ey - sy;
    adx = dxs[WB-1] ? -dxs : dxs;
    ady = dys[WB-1] ? -dys : dys;

    if (!dxs[WB-1] && !dys[WB-1]) begin
      oct_new = (adx >= ady) ? OCT_0 : OCT_1;
    end else if ((dxs <= 0) && !dys[WB-1]) begin
      oct_new = (ady >= adx) ? OCT_2 : OCT_3;
    end else if ((dxs <= 0) && (dys <= 0)) begin
      oct_new = (adx >= ady) ? OCT_4 : OCT_5;
    end else begin
      oct_new = (ady >= adx) ? OCT_6 : OCT_7;
    end

    ws  = to_zero(oct_new, '{x: sx, y: sy});
    we  = to_zero(oct_new, '{x: ex, y: ey});
    dx0 = (adx >= ady) ? adx : ady;
    dy0 = (adx >= ady) ? ady : adx;
  end

  // step
  always_comb begin
    go_diag   = !decision_q[DB-1];
    nwx       = walk_x_q + WB'(1);
    nwy       = go_diag ? walk_y_q + WB'(1) : walk_y_q;
    step_last = (nwx >= stop_x_q);
  end

  // next state and result
  always_comb begin
    octant_d       = octant_q;
    walk_x_d       = walk_x_q;
    walk_y_d       = walk_y_q;
    stop_x_d       = stop_x_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    active_d       = active_q;
    emit_pt        = '{x: walk_x_q, y: walk_y_q};
    emit_oct       = octant_q;
    pixel_valid_d  = 1'b0;
    pixel_last_d   = 1'b0;

    if (is_start) begin
      octant_d       = oct_new;
      walk_x_d       = ws.x;
      walk_y_d       = ws.y;
      stop_x_d       = we.x;
      decision_d     = (DB'(dy0) <<< 1) - DB'(dx0);
      inc_straight_d = IB'(dy0) <<< 1;
      inc_diagonal_d = (IB'(dy0) - IB'(dx0)) <<< 1;
      active_d       = (dx0 != '0);
      emit_pt        = ws;
      emit_oct       = oct_new;
      pixel_valid_d  = 1'b1;
      pixel_last_d   = (dx0 == '0);
    end else if (active_q) begin
      walk_x_d      = nwx;
      walk_y_d      = nwy;
      decision_d    = go_diag ? decision_q + DB'(inc_diagonal_q)
                              : decision_q + DB'(inc_straight_q);
      active_d      = !step_last;
      emit_pt       = '{x: nwx, y: nwy};
      pixel_valid_d = 1'b1;
      pixel_last_d  = step_last;
    end

    map_pt = from_zero(emit_oct, emit_pt);
    if (pixel_valid_d) begin
      pixel_x_d = map_pt.x[COORD_BITS-1:0];
      pixel_y_d = map_pt.y[COORD_BITS-1:0];
    end else begin
      pixel_x_d = '0;
      pixel_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octant_q       <= OCT_0;
      walk_x_q       <= '0;
      walk_y_q       <= '0;
      stop_x_q       <= '0;
      decision_q     <= '0;
      inc_straight_q <= '0;
      inc_diagonal_q <= '0;
      active_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (req_fire) begin
        octant_q       <= octant_d;
        walk_x_q       <= walk_x_d;
        walk_y_q       <= walk_y_d;
        stop_x_q       <= stop_x_d;
        decision_q     <= decision_d;
        inc_straight_q <= inc_straight_d;
        inc_diagonal_q <= inc_diagonal_d;
        active_q       <= active_d;
        out_valid_q    <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      pixel_x_q     <= pixel_x_d;
      pixel_y_q     <= pixel_y_d;
      pixel_valid_q <= pixel_valid_d;
      pixel_last_q  <= pixel_last_d;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = pixel_x_q;
  assign pix_o.pixel_y     = pixel_y_q;
  assign pix_o.pixel_valid = pixel_valid_q;
  assign pix_o.pixel_last  = pixel_last_q;

  a_active_before_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (walk_x_q < stop_x_q))
    else $error("active line already at its end");

  a_degenerate_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && is_start && (dx0 == '0)) |=> !active_q)
    else $error("single-pixel line left active");

  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && !is_start && active_q && step_last) |=> (!active_q && pix_o.pixel_last))
    else $error("last pixel did not end the line");

  a_idle_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && !pix_o.pixel_valid) |->
      ((pix_o.pixel_x == '0) && (pix_o.pixel_y == '0) && !pix_o.pixel_last))
    else $error("idle result carries data");

endmodule
